// ===== rtl/core/btd_pkg.sv =====
// btd_pkg: shared types and constants of the backlight timeout dimmer
// holds event and screen state codes, register indexes and the controller state record
// no dependencies
package btd_pkg;

	// field widths and fixed constants
	localparam int CNT_W      = 22;
	localparam int SEC_W      = 12;
	localparam int LVL_W      = 7;
	localparam int MS_PER_S   = 1000;
	localparam int FULL_LEVEL = 100;

	// event kinds carried on the input tuser
	typedef enum logic [2:0] {
		EV_TICK     = 3'd0,
		EV_ACTIVITY = 3'd1,
		EV_START    = 3'd2,
		EV_STOP     = 3'd3,
		EV_PLAYBACK = 3'd4,
		EV_DOOR     = 3'd5
	} event_t;

	// screen state codes
	typedef enum logic [1:0] {
		ST_ACTIVE  = 2'd0,
		ST_DIMMING = 2'd1,
		ST_DIMMED  = 2'd2,
		ST_OFF     = 2'd3
	} screen_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_ENABLE      = 2'd0,
		REG_DIM_TIMEOUT = 2'd1,
		REG_OFF_TIMEOUT = 2'd2,
		REG_DIM_LEVEL   = 2'd3
	} cfg_reg_t;

	// controller state apart from the ramp interval counter
	typedef struct packed {
		screen_t          cur_state;
		logic [LVL_W-1:0] level;
		logic [LVL_W-1:0] step;
		logic [CNT_W-1:0] dim_count;
		logic             dim_running;
		logic [CNT_W-1:0] off_count;
		logic             off_running;
		logic             ramp_running;
		logic             suppressed;
		logic             door_closing;
		logic             power;
		logic             dimmed;
	} ctl_t;

endpackage

// ===== rtl/core/backlight_timeout_dimmer_top.sv =====
// backlight_timeout_dimmer_top: display backlight timeout controller
// input beat register, one-pass event logic, result register; uses btd_pkg
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+------------------------------------------
//  s_*       | in  | s_tvalid/s_tready  | tuser: mode; tdata: playing, door_open
//  m_*       | out | m_tvalid/m_tready  | tdata: power, brightness, dimmed, state, changed
//  cfg_*     | in  | cfg_we (no wait)   | cfg_idx selects register, cfg_data value
//
// one beat enters the input register and one result leaves the result register per
// cycle while the result is not stalled; an accepted beat passes the input register,
// then the result register. the event logic reads and writes the timer and ramp state
// in the same cycle, so consecutive events need no spacing. a stalled result holds its
// register and the input register fills behind it before s_tready drops.
// reset (arst_n low) restores the register defaults and the active, full-bright state.
module backlight_timeout_dimmer_top
	import btd_pkg::*;
#(
	parameter int RAMP_STEPS        = 20,
	parameter int RAMP_INTERVAL_MS  = 50,
	parameter int DOOR_OFF_DELAY_MS = 2000
) (
	input  logic              clk,
	input  logic              arst_n,
	// event input
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [0] playing, [1] door_open, rest zero
	input  logic [2:0]        s_tuser,   // [2:0] mode
	// result output
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // [0] power_on, [7:1] brightness,
	                                     // [8] dimmed_flag, [10:9] screen_state,
	                                     // [11] state_changed, rest zero
	// configuration writes
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [SEC_W-1:0]  cfg_data
);

	localparam int RC_W    = $clog2(RAMP_INTERVAL_MS + 1);
	localparam int RECIP_K = 16;
	localparam int RECIP   = ((2 ** RECIP_K) + RAMP_STEPS - 1) / RAMP_STEPS;
	localparam int RECIP_W = RECIP_K + 1;
	localparam int PROD_W  = LVL_W + RECIP_W;

	// configuration registers
	logic             enable_q;
	logic [SEC_W-1:0] dim_timeout_q;
	logic [SEC_W-1:0] off_timeout_q;
	logic [LVL_W-1:0] dim_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b1;
			dim_timeout_q <= SEC_W'(30);
			off_timeout_q <= SEC_W'(60);
			dim_level_q   <= LVL_W'(20);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_ENABLE:      enable_q      <= cfg_data[0];
				REG_DIM_TIMEOUT: dim_timeout_q <= cfg_data;
				REG_OFF_TIMEOUT: off_timeout_q <= cfg_data;
				REG_DIM_LEVEL:   dim_level_q   <= cfg_data[LVL_W-1:0];
				default:         ;
			endcase
		end
	end

	// input beat register
	logic       valid_s1;
	logic [2:0] mode_s1;
	logic       playing_s1;
	logic       door_open_s1;
	logic       adv;

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1      <= s_tuser;
			playing_s1   <= s_tdata[0];
			door_open_s1 <= s_tdata[1];
		end
	end

	// values derived from the configuration
	logic [LVL_W-1:0]  tgt;
	logic [LVL_W-1:0]  span;
	logic [PROD_W-1:0] prod;
	logic [LVL_W-1:0]  quot;
	logic [LVL_W-1:0]  step_new;
	logic [CNT_W-1:0]  dim_load;
	logic              off_nonpos;
	logic [CNT_W-1:0]  off_load;

	always_comb begin
		tgt        = (dim_level_q > LVL_W'(FULL_LEVEL)) ? LVL_W'(FULL_LEVEL) : dim_level_q;
		span       = LVL_W'(FULL_LEVEL) - tgt;
		// span / RAMP_STEPS through a reciprocal, exact for span up to 100
		prod       = PROD_W'(span) * PROD_W'(RECIP);
		quot       = prod[RECIP_K +: LVL_W];
		step_new   = (quot == '0) ? LVL_W'(1) : quot;
		dim_load   = CNT_W'(dim_timeout_q) * CNT_W'(MS_PER_S);
		off_nonpos = (off_timeout_q <= dim_timeout_q);
		off_load   = CNT_W'(off_timeout_q - dim_timeout_q) * CNT_W'(MS_PER_S);
	end

	// controller state
	ctl_t           st_q;
	ctl_t           st_n;
	logic [RC_W-1:0] ramp_cnt_q;
	logic [RC_W-1:0] ramp_cnt_n;

	// event logic: off timer, then ramp, then dim timer on a tick
	always_comb begin
		logic signed [LVL_W:0] lvl_dec;
		st_n       = st_q;
		ramp_cnt_n = ramp_cnt_q;
		lvl_dec    = '0;
		case (event_t'(mode_s1))
			EV_TICK: begin
				// off timer
				if (st_n.off_running) begin
					if (st_n.off_count <= CNT_W'(1)) begin
						st_n.off_running = 1'b0;
						if (!st_n.suppressed) begin
							st_n.power     = 1'b0;
							st_n.dimmed    = 1'b1;
							st_n.cur_state = ST_OFF;
						end
					end else begin
						st_n.off_count = st_n.off_count - CNT_W'(1);
					end
				end
				// ramp step
				if (st_n.ramp_running) begin
					if (ramp_cnt_n <= RC_W'(1)) begin
						ramp_cnt_n = RC_W'(RAMP_INTERVAL_MS);
						lvl_dec    = $signed({1'b0, st_n.level}) - $signed({1'b0, st_n.step});
						if (lvl_dec > $signed({1'b0, tgt})) begin
							st_n.level = lvl_dec[LVL_W-1:0];
						end else begin
							st_n.level        = tgt;
							st_n.ramp_running = 1'b0;
							st_n.cur_state    = ST_DIMMED;
							if (st_n.door_closing) begin
								st_n.door_closing = 1'b0;
								st_n.off_count    = CNT_W'(DOOR_OFF_DELAY_MS);
								st_n.off_running  = 1'b1;
							end else if (off_nonpos) begin
								if (!st_n.suppressed) begin
									st_n.power     = 1'b0;
									st_n.dimmed    = 1'b1;
									st_n.cur_state = ST_OFF;
								end
							end else begin
								st_n.off_count   = off_load;
								st_n.off_running = 1'b1;
							end
						end
					end else begin
						ramp_cnt_n = ramp_cnt_n - RC_W'(1);
					end
				end
				// dim timer
				if (st_n.dim_running) begin
					if (st_n.dim_count <= CNT_W'(1)) begin
						st_n.dim_running = 1'b0;
						if (!st_n.suppressed) begin
							st_n.cur_state    = ST_DIMMING;
							st_n.level        = LVL_W'(FULL_LEVEL);
							st_n.step         = step_new;
							ramp_cnt_n        = RC_W'(RAMP_INTERVAL_MS);
							st_n.ramp_running = 1'b1;
						end
					end else begin
						st_n.dim_count = st_n.dim_count - CNT_W'(1);
					end
				end
			end
			EV_ACTIVITY, EV_DOOR: begin
				if (event_t'(mode_s1) == EV_ACTIVITY || door_open_s1) begin
					// user activity or door opened: wake the screen
					if (enable_q) begin
						st_n.ramp_running = 1'b0;
						st_n.off_running  = 1'b0;
						st_n.door_closing = 1'b0;
						if (st_n.cur_state != ST_ACTIVE) begin
							st_n.power     = 1'b1;
							st_n.level     = LVL_W'(FULL_LEVEL);
							st_n.dimmed    = 1'b0;
							st_n.cur_state = ST_ACTIVE;
						end
						if (!st_n.suppressed) begin
							st_n.dim_count   = dim_load;
							st_n.dim_running = 1'b1;
						end
					end
				end else if (enable_q) begin
					// door closed: start the ramp at once
					st_n.dim_running  = 1'b0;
					st_n.off_running  = 1'b0;
					st_n.door_closing = 1'b1;
					st_n.cur_state    = ST_DIMMING;
					st_n.level        = LVL_W'(FULL_LEVEL);
					st_n.step         = step_new;
					ramp_cnt_n        = RC_W'(RAMP_INTERVAL_MS);
					st_n.ramp_running = 1'b1;
				end
			end
			EV_START: begin
				if (enable_q) begin
					st_n.cur_state = ST_ACTIVE;
					st_n.level     = LVL_W'(FULL_LEVEL);
					if (playing_s1) begin
						st_n.suppressed = 1'b1;
					end else begin
						st_n.suppressed  = 1'b0;
						st_n.dim_count   = dim_load;
						st_n.dim_running = 1'b1;
					end
				end
			end
			EV_STOP: begin
				st_n.dim_running  = 1'b0;
				st_n.off_running  = 1'b0;
				st_n.ramp_running = 1'b0;
			end
			EV_PLAYBACK: begin
				if (playing_s1) begin
					st_n.suppressed   = 1'b1;
					st_n.dim_running  = 1'b0;
					st_n.off_running  = 1'b0;
					st_n.ramp_running = 1'b0;
				end else if (st_n.suppressed) begin
					st_n.suppressed = 1'b0;
					if (enable_q && st_n.cur_state == ST_ACTIVE) begin
						st_n.dim_count   = dim_load;
						st_n.dim_running = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// state registers advance with each event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.cur_state    <= ST_ACTIVE;
			st_q.level        <= LVL_W'(FULL_LEVEL);
			st_q.step         <= LVL_W'(1);
			st_q.dim_count    <= '0;
			st_q.dim_running  <= 1'b0;
			st_q.off_count    <= '0;
			st_q.off_running  <= 1'b0;
			st_q.ramp_running <= 1'b0;
			st_q.suppressed   <= 1'b0;
			st_q.door_closing <= 1'b0;
			st_q.power        <= 1'b1;
			st_q.dimmed       <= 1'b0;
			ramp_cnt_q        <= '0;
		end else if (adv) begin
			st_q       <= st_n;
			ramp_cnt_q <= ramp_cnt_n;
		end
	end

	// result register
	logic        out_valid_q;
	logic [15:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {4'b0000, (st_n.cur_state != st_q.cur_state), st_n.cur_state,
			               st_n.dimmed, st_n.level, st_n.power};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== rtl/core/btd_checker.sv =====
// btd_checker: port-level checks of the backlight timeout dimmer result stream
// watches the ports of backlight_timeout_dimmer_top only; uses btd_pkg
// ends with the bind that attaches it to the top level
module btd_checker
	import btd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	logic    out_beat;
	screen_t last_state_q;

	assign out_beat = m_tvalid && m_tready;

	// screen state of the last delivered beat, active after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_state_q <= ST_ACTIVE;
		end else if (out_beat) begin
			last_state_q <= screen_t'(m_tdata[10:9]);
		end
	end

	// brightness never exceeds full scale
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:1] <= 7'd100))
		else $error("brightness above 100");

	// off state always reports the dimmed flag
	a_off_dimmed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[10:9] == ST_OFF) |-> m_tdata[8])
		else $error("off state without dimmed flag");

	// power is only removed together with the dimmed flag
	a_power_dimmed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> m_tdata[8])
		else $error("power off without dimmed flag");

	// state change flag matches the previous beat's state
	a_changed: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> (m_tdata[11] == (m_tdata[10:9] != last_state_q)))
		else $error("state_changed inconsistent with state sequence");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result beat changed");

endmodule

bind backlight_timeout_dimmer_top btd_checker u_btd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
